// ===== hw/rtl/sbr_pkg.sv =====
`default_nettype none

package sbr_pkg;

  // Fixed field widths of the stream transactions.
  localparam int unsigned IdxW   = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SpaceW = 7;
  localparam int unsigned CountW = 7;

  // Operations of the shared 64-bit adder.
  typedef enum logic [1:0] {
    ALU_END  = 2'd0,  // index + has_byte
    ALU_EOFF = 2'd1,  // end position - next expected
    ALU_OFF  = 2'd2,  // index - next expected
    ALU_ADV  = 2'd3   // next expected + run length
  } alu_op_e;

  // Sequencer states.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_END   = 10'b00_0000_0010,
    S_EOFF  = 10'b00_0000_0100,
    S_PURGE = 10'b00_0000_1000,
    S_OFF   = 10'b00_0001_0000,
    S_CHK   = 10'b00_0010_0000,
    S_DRAIN = 10'b00_0100_0000,
    S_ADV   = 10'b00_1000_0000,
    S_RD    = 10'b01_0000_0000,
    S_LD    = 10'b10_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/sbr_in_if.sv =====
`default_nettype none

interface sbr_in_if;
  import sbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   stream_index;
  logic [ByteW-1:0]  data_byte;
  logic              has_byte;
  logic              ends_stream;
  logic [SpaceW-1:0] output_space;

  modport source (
    output valid, stream_index, data_byte, has_byte, ends_stream, output_space,
    input  ready
  );

  modport sink (
    input  valid, stream_index, data_byte, has_byte, ends_stream, output_space,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/sbr_out_if.sv =====
`default_nettype none

interface sbr_out_if;
  import sbr_pkg::*;

  logic              valid;
  logic              ready;
  logic              byte_valid;
  logic [ByteW-1:0]  out_byte;
  logic              last_of_run;
  logic              stream_closed;
  logic [CountW-1:0] pending_bytes;

  modport source (
    output valid, byte_valid, out_byte, last_of_run, stream_closed, pending_bytes,
    input  ready
  );

  modport sink (
    input  valid, byte_valid, out_byte, last_of_run, stream_closed, pending_bytes,
    output ready
  );

endinterface

`default_nettype wire

// ===== hw/rtl/sbr_ram.sv =====
`default_nettype none

module sbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbr_alu.sv =====
`default_nettype none

module sbr_alu (
  input  sbr_pkg::alu_op_e               op_i,
  input  logic [sbr_pkg::IdxW-1:0]       idx_i,
  input  logic                           has_i,
  input  logic [sbr_pkg::IdxW-1:0]       end_pos_i,
  input  logic [sbr_pkg::IdxW-1:0]       nexp_i,
  input  logic [sbr_pkg::CountW-1:0]     run_len_i,
  output logic [sbr_pkg::IdxW-1:0]       sum_o
);
  import sbr_pkg::*;

  logic [IdxW-1:0] opa;
  logic [IdxW-1:0] opb;
  logic            sub;

  always_comb begin
    opa = nexp_i;
    opb = IdxW'(run_len_i);
    sub = 1'b0;
    unique case (op_i)
      ALU_END: begin
        opa = idx_i;
        opb = IdxW'(has_i);
      end
      ALU_EOFF: begin
        opa = end_pos_i;
        opb = nexp_i;
        sub = 1'b1;
      end
      ALU_OFF: begin
        opa = idx_i;
        opb = nexp_i;
        sub = 1'b1;
      end
      ALU_ADV: begin
        opa = nexp_i;
        opb = IdxW'(run_len_i);
      end
      default: begin
        opa = nexp_i;
        opb = IdxW'(run_len_i);
      end
    endcase
  end

  // Two's complement subtract: invert and carry in.
  assign sum_o = opa + (sub ? ~opb : opb) + IdxW'(sub);

endmodule

`default_nettype wire

// ===== hw/rtl/stream_byte_reassembler.sv =====
`default_nettype none

// In-order byte stream reassembler. Each input transaction carries at most one
// stream byte with its absolute 64-bit index, an optional end mark and the free
// space downstream. The byte at the next expected index goes out at once, then
// held bytes that follow drain in order, bounded by min(output_space,
// WINDOW_DEPTH) and by a known end. Bytes ahead of the next index but inside
// that bound wait in a WINDOW_DEPTH-entry ring store; duplicates, stale bytes
// and bytes beyond the window or the end are dropped. Every input transaction
// yields one result transaction per emitted byte, or one report with
// byte_valid low when nothing goes out; each result carries the held count and
// the closed flag as they stand after the whole input. The block takes one
// input at a time and accepts the next only once the last result of the
// current one is loaded; a first end mark adds one pass over the ring to
// discard held bytes past the end. The single 64-bit adder is used once per
// step, the ring store is walked one slot per cycle, and output backpressure
// stalls the loading of results.
module stream_byte_reassembler #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbr_in_if.sink    in_i,
  sbr_out_if.source res_o
);
  import sbr_pkg::*;

  localparam int unsigned SlotW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW  = $clog2(WINDOW_DEPTH + 1);

  localparam logic [SlotW-1:0]  SlotLast = SlotW'(WINDOW_DEPTH - 1);
  localparam logic [SlotW:0]    SlotWrap = (SlotW + 1)'(WINDOW_DEPTH);
  localparam logic [CntW-1:0]   CntLast  = CntW'(WINDOW_DEPTH - 1);
  localparam logic [SpaceW-1:0] SpaceCap = SpaceW'(WINDOW_DEPTH);

  // Sequencer
  state_e state_q, state_d;

  // Latched input transaction
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             has_q, has_d;
  logic             new_end_q, new_end_d;
  logic [CntW-1:0]  lim_q, lim_d;

  // Architectural stream state
  logic [IdxW-1:0]         nexp_q, nexp_d;
  logic                    end_known_q, end_known_d;
  logic [IdxW-1:0]         end_pos_q, end_pos_d;
  logic                    closed_q, closed_d;
  logic [WINDOW_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [SlotW-1:0]        head_q, head_d;

  // Per-transaction work registers
  logic [IdxW-1:0]  eoff_q, eoff_d;
  logic [IdxW-1:0]  off_q, off_d;
  logic [CntW-1:0]  pk_q, pk_d;
  logic [SlotW-1:0] pslot_q, pslot_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             direct_q, direct_d;
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [CntW-1:0]  e_q, e_d;

  // Output register
  logic              ovalid_q, ovalid_d;
  logic              obv_q, obv_d;
  logic [ByteW-1:0]  obyte_q, obyte_d;
  logic              olast_q, olast_d;
  logic              oclosed_q, oclosed_d;
  logic [CountW-1:0] opend_q, opend_d;

  // Shared adder and ring store
  alu_op_e          alu_op;
  logic [IdxW-1:0]  alu_sum;
  logic             ram_we;
  logic             ram_re;
  logic [ByteW-1:0] ram_rdata;

  // Narrow views of the end and byte offsets
  logic             eoff_small;
  logic [CntW-1:0]  eoff_lo;
  logic [CntW-1:0]  off_lo;
  logic             off_in_lim;
  logic             off_before_end;
  logic             byte_ok;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] byte_slot;
  logic             at_end;
  logic             out_load;
  logic             run_last;

  assign eoff_small     = (eoff_q[IdxW-1:CntW] == '0);
  assign eoff_lo        = eoff_q[CntW-1:0];
  assign off_lo         = off_q[CntW-1:0];
  assign off_in_lim     = (off_q[IdxW-1:CntW] == '0) && (off_lo < lim_q);
  assign off_before_end = !eoff_small || (off_lo < eoff_lo);
  assign byte_ok        = has_q && off_in_lim && (!end_known_q || off_before_end);

  // Slot of the incoming byte: head plus offset, wrapped once (offset < depth).
  assign slot_sum  = {1'b0, head_q} + {1'b0, off_q[SlotW-1:0]};
  assign byte_slot = (slot_sum >= SlotWrap) ? SlotW'(slot_sum - SlotWrap)
                                            : slot_sum[SlotW-1:0];

  // The end is reached once the emitted count equals the end offset.
  assign at_end = end_known_q && eoff_small && (n_q == eoff_lo);

  assign out_load = (state_q == S_LD) && (!ovalid_q || res_o.ready);
  assign run_last = (n_q == '0) || (CntW'(e_q + 1'b1) == n_q);

  always_comb begin
    unique case (state_q)
      S_END:   alu_op = ALU_END;
      S_EOFF:  alu_op = ALU_EOFF;
      S_OFF:   alu_op = ALU_OFF;
      default: alu_op = ALU_ADV;
    endcase
  end

  sbr_alu u_alu (
    .op_i      (alu_op),
    .idx_i     (idx_q),
    .has_i     (has_q),
    .end_pos_i (end_pos_q),
    .nexp_i    (nexp_q),
    .run_len_i (CountW'(n_q)),
    .sum_o     (alu_sum)
  );

  sbr_ram #(
    .Width (ByteW),
    .Depth (WINDOW_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_slot),
    .wdata_i (byte_q),
    .re_i    (ram_re),
    .raddr_i (rd_slot_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    byte_d      = byte_q;
    has_d       = has_q;
    new_end_d   = new_end_q;
    lim_d       = lim_q;
    nexp_d      = nexp_q;
    end_known_d = end_known_q;
    end_pos_d   = end_pos_q;
    closed_d    = closed_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    eoff_d      = eoff_q;
    off_d       = off_q;
    pk_d        = pk_q;
    pslot_d     = pslot_q;
    n_d         = n_q;
    direct_d    = direct_q;
    rd_slot_d   = rd_slot_q;
    e_d         = e_q;
    obv_d       = obv_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    oclosed_d   = oclosed_q;
    opend_d     = opend_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    // Drop the output transaction once taken; a new load overrides below.
    ovalid_d = ovalid_q && !res_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          idx_d     = in_i.stream_index;
          byte_d    = in_i.data_byte;
          has_d     = in_i.has_byte;
          new_end_d = in_i.ends_stream && !end_known_q;
          lim_d     = (in_i.output_space >= SpaceCap) ? CntW'(WINDOW_DEPTH)
                                                      : CntW'(in_i.output_space);
          state_d   = (in_i.ends_stream && !end_known_q) ? S_END : S_EOFF;
        end
      end

      S_END: begin
        // Record the first end mark only.
        end_known_d = 1'b1;
        end_pos_d   = alu_sum;
        state_d     = S_EOFF;
      end

      S_EOFF: begin
        eoff_d  = alu_sum;
        pk_d    = '0;
        pslot_d = head_q;
        state_d = new_end_q ? S_PURGE : S_OFF;
      end

      S_PURGE: begin
        // Walk the ring from the head; drop held bytes at or past the end.
        if (eoff_small && (pk_q >= eoff_lo) && valid_q[pslot_q]) begin
          valid_d[pslot_q] = 1'b0;
          cnt_d            = cnt_q - 1'b1;
        end
        pk_d    = pk_q + 1'b1;
        pslot_d = (pslot_q == SlotLast) ? '0 : pslot_q + 1'b1;
        if (pk_q == CntLast) begin
          state_d = S_OFF;
        end
      end

      S_OFF: begin
        off_d   = alu_sum;
        state_d = S_CHK;
      end

      S_CHK: begin
        direct_d = 1'b0;
        n_d      = '0;
        if (byte_ok) begin
          if (off_q == '0) begin
            // In-order byte: emit it and drop any held copy.
            if (valid_q[head_q]) begin
              valid_d[head_q] = 1'b0;
              cnt_d           = cnt_q - 1'b1;
            end
            direct_d = 1'b1;
            n_d      = CntW'(1);
            head_d   = (head_q == SlotLast) ? '0 : head_q + 1'b1;
          end else if (!valid_q[byte_slot]) begin
            valid_d[byte_slot] = 1'b1;
            ram_we             = 1'b1;
            cnt_d              = cnt_q + 1'b1;
          end
        end
        rd_slot_d = head_d;
        state_d   = S_DRAIN;
      end

      S_DRAIN: begin
        // Advance through held bytes while space remains and the end is ahead.
        if ((n_q < lim_q) && !at_end && valid_q[head_q]) begin
          valid_d[head_q] = 1'b0;
          cnt_d           = cnt_q - 1'b1;
          head_d          = (head_q == SlotLast) ? '0 : head_q + 1'b1;
          n_d             = n_q + 1'b1;
        end else begin
          state_d = S_ADV;
        end
      end

      S_ADV: begin
        nexp_d   = alu_sum;
        closed_d = closed_q || at_end;
        e_d      = '0;
        state_d  = S_RD;
      end

      S_RD: begin
        ram_re  = (n_q != '0) && !direct_q;
        state_d = S_LD;
      end

      S_LD: begin
        if (out_load) begin
          ovalid_d  = 1'b1;
          obv_d     = (n_q != '0);
          obyte_d   = (n_q == '0) ? '0 : (direct_q ? byte_q : ram_rdata);
          olast_d   = run_last;
          oclosed_d = closed_q;
          opend_d   = CountW'(cnt_q);
          if (run_last) begin
            state_d = S_IDLE;
          end else begin
            if (direct_q) begin
              direct_d = 1'b0;
            end else begin
              rd_slot_d = (rd_slot_q == SlotLast) ? '0 : rd_slot_q + 1'b1;
            end
            e_d     = e_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nexp_q      <= '0;
      end_known_q <= 1'b0;
      end_pos_q   <= '0;
      closed_q    <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      nexp_q      <= nexp_d;
      end_known_q <= end_known_d;
      end_pos_q   <= end_pos_d;
      closed_q    <= closed_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      ovalid_q    <= ovalid_d;
    end
  end

  // Payload and work registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    byte_q    <= byte_d;
    has_q     <= has_d;
    new_end_q <= new_end_d;
    lim_q     <= lim_d;
    eoff_q    <= eoff_d;
    off_q     <= off_d;
    pk_q      <= pk_d;
    pslot_q   <= pslot_d;
    n_q       <= n_d;
    direct_q  <= direct_d;
    rd_slot_q <= rd_slot_d;
    e_q       <= e_d;
    obv_q     <= obv_d;
    obyte_q   <= obyte_d;
    olast_q   <= olast_d;
    oclosed_q <= oclosed_d;
    opend_q   <= opend_d;
  end

  assign in_i.ready = (state_q == S_IDLE);

  assign res_o.valid         = ovalid_q;
  assign res_o.byte_valid    = obv_q;
  assign res_o.out_byte      = obyte_q;
  assign res_o.last_of_run   = olast_q;
  assign res_o.stream_closed = oclosed_q;
  assign res_o.pending_bytes = opend_q;

endmodule

`default_nettype wire
